FILE: rtl/skrs_pkg.sv
// Shared types and constants for the string key rank sorter.
// Holds the channel payload structs and the ranker status struct.
// No dependencies.
package skrs_pkg;

  localparam int CHAR_W    = 8;
  localparam int OUT_IDX_W = 3;

  // Byte value that ends a key.
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_key;
  } skrs_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] sorted_pos;
    logic [OUT_IDX_W-1:0] src_index;
    logic                 overflow;
    logic                 last_result;
  } skrs_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } skrs_rank_stat_t;

endpackage

FILE: rtl/string_key_rank_sort.sv
// Top level of the string key rank sorter: byte loading and set bookkeeping,
// wired to the key store, the rank sequencer and the result stage.
// Depends on skrs_pkg, skrs_store, skrs_ranker and skrs_emit.
//
//   Channel | Direction | Transaction
//   in      | input     | one key byte, or a terminator (optionally ending the set)
//   out     | output    | one sorted position with its load index and flags
//
// Bytes and plain terminators are accepted whenever in_stall_o is low. The final
// terminator starts the ranking walk over the key memory, which compares each
// ordered pair of distinct keys by length and then byte by byte over their common
// part. The results then follow in sorted order, each held while out is stalled.
// in_stall_o is high from the final terminator until the result stage reports done
// after the last result has been taken.
// Reset clears state, counters and flags only; the memories need no clearing pass.
module string_key_rank_sort #(
  parameter int NUM_KEYS = 8,
  parameter int MAX_LEN  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  skrs_pkg::skrs_in_t  in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output skrs_pkg::skrs_out_t out_o
);
  import skrs_pkg::*;

  localparam int KW = $clog2(NUM_KEYS);
  localparam int CW = $clog2(NUM_KEYS + 1);
  localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_RANK  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [LW-1:0] pos_q, pos_d;
  logic          ovf_q, ovf_d;

  logic          in_acc;
  logic          is_char;
  logic          has_room;
  logic          pos_room;
  logic          key_we;
  logic          len_we;

  logic [KW-1:0]     rd_key_a;
  logic [KW-1:0]     rd_key_b;
  logic [PW-1:0]     rd_pos;
  logic [CHAR_W-1:0] rd_char_a;
  logic [CHAR_W-1:0] rd_char_b;
  logic [LW-1:0]     rd_len_a;
  logic [LW-1:0]     rd_len_b;

  skrs_rank_stat_t rank_stat;
  logic            rank_we;
  logic [KW-1:0]   rank_pos;
  logic [KW-1:0]   rank_idx;
  logic            emit_done;

  assign in_stall_o = state_q != ST_LOAD;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_char    = in_i.char_code != CHAR_NUL;
  assign has_room   = count_q < CW'(NUM_KEYS);
  assign pos_room   = pos_q < LW'(MAX_LEN);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    key_we  = 1'b0;
    len_we  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (is_char) begin
            // Bytes of a key past the length bound, or of a key past the
            // count bound, are dropped.
            if (has_room && pos_room) begin
              key_we = 1'b1;
              pos_d  = pos_q + LW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            if (has_room) begin
              len_we  = 1'b1;
              count_d = count_q + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
            pos_d = '0;
            if (in_i.last_key) begin
              state_d = ST_START;
            end
          end
        end
      end
      ST_START: begin
        state_d = ST_RANK;
      end
      ST_RANK: begin
        if (rank_stat.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          count_d = '0;
          pos_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
    end
  end

  skrs_store #(
    .NUM_KEYS(NUM_KEYS),
    .MAX_LEN (MAX_LEN)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (key_we),
    .wr_key_i    (count_q[KW-1:0]),
    .wr_pos_i    (pos_q[PW-1:0]),
    .wr_char_i   (in_i.char_code),
    .len_wr_en_i (len_we),
    .len_wr_key_i(count_q[KW-1:0]),
    .len_wr_val_i(pos_q),
    .rd_key_a_i  (rd_key_a),
    .rd_key_b_i  (rd_key_b),
    .rd_pos_i    (rd_pos),
    .rd_char_a_o (rd_char_a),
    .rd_char_b_o (rd_char_b),
    .rd_len_a_o  (rd_len_a),
    .rd_len_b_o  (rd_len_b)
  );

  skrs_ranker #(
    .NUM_KEYS(NUM_KEYS),
    .MAX_LEN (MAX_LEN)
  ) u_ranker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_START),
    .num_i      (count_q),
    .stat_o     (rank_stat),
    .rd_key_a_o (rd_key_a),
    .rd_key_b_o (rd_key_b),
    .rd_pos_o   (rd_pos),
    .rd_char_a_i(rd_char_a),
    .rd_char_b_i(rd_char_b),
    .rd_len_a_i (rd_len_a),
    .rd_len_b_i (rd_len_b),
    .rank_we_o  (rank_we),
    .rank_pos_o (rank_pos),
    .rank_idx_o (rank_idx)
  );

  skrs_emit #(
    .NUM_KEYS(NUM_KEYS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_RANK && rank_stat.done),
    .num_i      (count_q),
    .ovf_i      (ovf_q),
    .rank_we_i  (rank_we),
    .rank_pos_i (rank_pos),
    .rank_idx_i (rank_idx),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o),
    .done_o     (emit_done)
  );

  a_no_load_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while results are pending");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NUM_KEYS))
    else $error("key count past its bound");

  a_rank_before_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_stat.busy |-> !out_valid_o)
    else $error("result shown while ranking is still running");

endmodule

FILE: rtl/skrs_store.sv
// Key byte memory and key length memory of the string key rank sorter.
// One write port and two registered read ports on each memory.
// Depends on skrs_pkg.
module skrs_store #(
  parameter int NUM_KEYS = 8,
  parameter int MAX_LEN  = 16,
  localparam int KW = $clog2(NUM_KEYS),
  localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [KW-1:0]               wr_key_i,
  input  logic [PW-1:0]               wr_pos_i,
  input  logic [skrs_pkg::CHAR_W-1:0] wr_char_i,
  input  logic                        len_wr_en_i,
  input  logic [KW-1:0]               len_wr_key_i,
  input  logic [LW-1:0]               len_wr_val_i,
  input  logic [KW-1:0]               rd_key_a_i,
  input  logic [KW-1:0]               rd_key_b_i,
  input  logic [PW-1:0]               rd_pos_i,
  output logic [skrs_pkg::CHAR_W-1:0] rd_char_a_o,
  output logic [skrs_pkg::CHAR_W-1:0] rd_char_b_o,
  output logic [LW-1:0]               rd_len_a_o,
  output logic [LW-1:0]               rd_len_b_o
);
  import skrs_pkg::*;

  localparam int DEPTH = NUM_KEYS * MAX_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] ROW = AW'(MAX_LEN);

  logic [CHAR_W-1:0] key_mem [DEPTH];
  logic [LW-1:0]     len_mem [NUM_KEYS];

  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [CHAR_W-1:0] rd_char_a_q;
  logic [CHAR_W-1:0] rd_char_b_q;
  logic [LW-1:0]     rd_len_a_q;
  logic [LW-1:0]     rd_len_b_q;

  // Each key owns one row of MAX_LEN bytes.
  assign wr_addr   = AW'(wr_key_i) * ROW + AW'(wr_pos_i);
  assign rd_addr_a = AW'(rd_key_a_i) * ROW + AW'(rd_pos_i);
  assign rd_addr_b = AW'(rd_key_b_i) * ROW + AW'(rd_pos_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr] <= wr_char_i;
    end
    rd_char_a_q <= key_mem[rd_addr_a];
    rd_char_b_q <= key_mem[rd_addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (len_wr_en_i) begin
      len_mem[len_wr_key_i] <= len_wr_val_i;
    end
    rd_len_a_q <= len_mem[rd_key_a_i];
    rd_len_b_q <= len_mem[rd_key_b_i];
  end

  assign rd_char_a_o = rd_char_a_q;
  assign rd_char_b_o = rd_char_b_q;
  assign rd_len_a_o  = rd_len_a_q;
  assign rd_len_b_o  = rd_len_b_q;

endmodule

FILE: rtl/skrs_ranker.sv
// Rank sequencer of the string key rank sorter: walks every key pair through
// the store's read ports, counts the keys that order lower and writes each rank.
// Depends on skrs_pkg.
module skrs_ranker #(
  parameter int NUM_KEYS = 8,
  parameter int MAX_LEN  = 16,
  localparam int KW = $clog2(NUM_KEYS),
  localparam int CW = $clog2(NUM_KEYS + 1),
  localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [CW-1:0]               num_i,
  output skrs_pkg::skrs_rank_stat_t   stat_o,
  output logic [KW-1:0]               rd_key_a_o,
  output logic [KW-1:0]               rd_key_b_o,
  output logic [PW-1:0]               rd_pos_o,
  input  logic [skrs_pkg::CHAR_W-1:0] rd_char_a_i,
  input  logic [skrs_pkg::CHAR_W-1:0] rd_char_b_i,
  input  logic [LW-1:0]               rd_len_a_i,
  input  logic [LW-1:0]               rd_len_b_i,
  output logic                        rank_we_o,
  output logic [KW-1:0]               rank_pos_o,
  output logic [KW-1:0]               rank_idx_o
);
  import skrs_pkg::*;

  localparam logic [2:0] RS_IDLE = 3'd0;
  localparam logic [2:0] RS_NEXT = 3'd1;
  localparam logic [2:0] RS_LEN  = 3'd2;
  localparam logic [2:0] RS_LENW = 3'd3;
  localparam logic [2:0] RS_RD   = 3'd4;
  localparam logic [2:0] RS_CMP  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic          done_q, done_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] n_q, n_d;
  logic [KW-1:0] r_q, r_d;
  logic [PW-1:0] k_q, k_d;
  logic [LW-1:0] min_q, min_d;
  logic          lt_q, lt_d;
  logic          eq_q, eq_d;
  logic          j_lower;
  logic          finish;
  logic          rank_we;

  // Key j is the candidate and key i the one being ranked: the a port
  // reads j and the b port reads i.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    i_d     = i_q;
    j_d     = j_q;
    n_d     = n_q;
    r_d     = r_q;
    k_d     = k_q;
    min_d   = min_q;
    lt_d    = lt_q;
    eq_d    = eq_q;
    j_lower = 1'b0;
    finish  = 1'b0;
    rank_we = 1'b0;
    unique case (state_q)
      RS_IDLE: begin
        if (start_i) begin
          n_d     = num_i;
          i_d     = '0;
          j_d     = '0;
          r_d     = '0;
          state_d = RS_NEXT;
        end
      end
      RS_NEXT: begin
        if (j_q == n_q) begin
          rank_we = 1'b1;
          r_d     = '0;
          j_d     = '0;
          i_d     = i_q + CW'(1);
          if (i_q + CW'(1) == n_q) begin
            done_d  = 1'b1;
            state_d = RS_IDLE;
          end
        end else if (j_q == i_q) begin
          j_d = j_q + CW'(1);
        end else begin
          state_d = RS_LEN;
        end
      end
      RS_LEN: begin
        state_d = RS_LENW;
      end
      RS_LENW: begin
        lt_d  = rd_len_a_i < rd_len_b_i;
        eq_d  = rd_len_a_i == rd_len_b_i;
        min_d = lt_d ? rd_len_a_i : rd_len_b_i;
        k_d   = '0;
        if (min_d == '0) begin
          j_lower = eq_d ? (j_q < i_q) : lt_d;
          finish  = 1'b1;
        end else begin
          state_d = RS_RD;
        end
      end
      RS_RD: begin
        state_d = RS_CMP;
      end
      RS_CMP: begin
        if (rd_char_a_i != rd_char_b_i) begin
          j_lower = rd_char_a_i < rd_char_b_i;
          finish  = 1'b1;
        end else if (LW'(k_q) + LW'(1) == min_q) begin
          // Common part equal: the shorter key is lower, equal keys go by index.
          j_lower = eq_q ? (j_q < i_q) : lt_q;
          finish  = 1'b1;
        end else begin
          k_d     = k_q + PW'(1);
          state_d = RS_RD;
        end
      end
      default: begin
        state_d = RS_IDLE;
      end
    endcase
    if (finish) begin
      r_d     = r_q + KW'(j_lower);
      j_d     = j_q + CW'(1);
      state_d = RS_NEXT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    n_q   <= n_d;
    r_q   <= r_d;
    k_q   <= k_d;
    min_q <= min_d;
    lt_q  <= lt_d;
    eq_q  <= eq_d;
  end

  assign stat_o.busy = state_q != RS_IDLE;
  assign stat_o.done = done_q;
  assign rd_key_a_o  = j_q[KW-1:0];
  assign rd_key_b_o  = i_q[KW-1:0];
  assign rd_pos_o    = k_q;
  assign rank_we_o   = rank_we;
  assign rank_pos_o  = r_q;
  assign rank_idx_o  = i_q[KW-1:0];

  a_byte_in_common_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == RS_CMP |-> LW'(k_q) < min_q)
    else $error("byte compare beyond the shorter key");

  a_rank_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_we_o |-> CW'(r_q) < n_q)
    else $error("rank written outside the loaded key count");

endmodule

FILE: rtl/skrs_emit.sv
// Result stage of the string key rank sorter: the position-to-index memory
// filled by the ranker, and the output register that walks it in order.
// Depends on skrs_pkg.
module skrs_emit #(
  parameter int NUM_KEYS = 8,
  localparam int KW = $clog2(NUM_KEYS),
  localparam int CW = $clog2(NUM_KEYS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CW-1:0]       num_i,
  input  logic                ovf_i,
  input  logic                rank_we_i,
  input  logic [KW-1:0]       rank_pos_i,
  input  logic [KW-1:0]       rank_idx_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output skrs_pkg::skrs_out_t out_o,
  output logic                done_o
);
  import skrs_pkg::*;

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_RD   = 2'd1;
  localparam logic [1:0] E_LOAD = 2'd2;
  localparam logic [1:0] E_OUT  = 2'd3;

  logic [KW-1:0] at_pos_mem [NUM_KEYS];
  logic [KW-1:0] rd_q;

  logic [1:0]    state_q, state_d;
  logic          valid_q, valid_d;
  logic          done_q, done_d;
  logic [KW-1:0] p_q, p_d;
  skrs_out_t     out_q, out_d;

  // The ranker fills this memory before the walk starts, so writes and reads
  // never meet on one entry.
  always_ff @(posedge clk_i) begin
    if (rank_we_i) begin
      at_pos_mem[rank_pos_i] <= rank_idx_i;
    end
    rd_q <= at_pos_mem[p_q];
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    done_d  = 1'b0;
    p_d     = p_q;
    out_d   = out_q;
    unique case (state_q)
      E_IDLE: begin
        if (start_i) begin
          p_d     = '0;
          state_d = E_RD;
        end
      end
      E_RD: begin
        state_d = E_LOAD;
      end
      E_LOAD: begin
        valid_d           = 1'b1;
        out_d.sorted_pos  = OUT_IDX_W'(p_q);
        out_d.src_index   = OUT_IDX_W'(rd_q);
        out_d.overflow    = ovf_i;
        out_d.last_result = CW'(p_q) + CW'(1) == num_i;
        state_d           = E_OUT;
      end
      E_OUT: begin
        if (!out_stall_i) begin
          valid_d = 1'b0;
          if (out_q.last_result) begin
            done_d  = 1'b1;
            state_d = E_IDLE;
          end else begin
            p_d     = p_q + KW'(1);
            state_d = E_RD;
          end
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;
  assign done_o      = done_q;

  a_done_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !valid_q)
    else $error("walk reported done with a result still held");

endmodule
